>>> hdl/dgbt_pkg.sv
// shared types, constants and helpers for the digraph binary tree checker
// no dependencies; imported by dgbt_store, dgbt_walk and the top level
package dgbt_pkg;

  // fixed field widths
  localparam int ROW_W         = 32;
  localparam int ROW_LW        = 5;
  localparam int CNT_W         = 6;
  localparam int REASON_W      = 3;
  localparam int MAX_NODES_DEF = 32;

  // verdict reason codes
  typedef enum logic [REASON_W-1:0] {
    RSN_NONE    = 3'd0,
    RSN_OUTDEG  = 3'd1,
    RSN_INDEG   = 3'd2,
    RSN_SOURCE  = 3'd3,
    RSN_UNREACH = 3'd4
  } reason_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_POP,
    ST_FETCH,
    ST_ROW,
    ST_EXPAND,
    ST_FINAL,
    ST_EMIT
  } walk_state_t;

  // status from the row store to the walk sequencer
  typedef struct packed {
    logic             outdeg_failed;
    logic [1:0]       indegree;
    logic [ROW_W-1:0] row;
  } store_rsp_t;

  // position of the lowest set bit, zero when none
  function automatic logic [ROW_LW-1:0] lowest_bit(input logic [ROW_W-1:0] v);
    logic [ROW_LW-1:0] pos;
    pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) pos = ROW_LW'(i);
    end
    return pos;
  endfunction

endpackage

>>> hdl/dgbt_store.sv
// adjacency row memory, row counter, out-degree flag and in-degree counters
// depends on dgbt_pkg
module dgbt_store import dgbt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clear,
  input  logic                                 row_wr,
  input  logic [ROW_W-1:0]                     row_data,
  input  logic [$clog2(MAX_NODES+1)-1:0]       n_eff,
  input  logic [$clog2(MAX_NODES)-1:0]         rd_node,
  input  logic [$clog2(MAX_NODES)-1:0]         scan_idx,
  output store_rsp_t                           rsp
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [CW-1:0]        row_cnt_r, row_cnt_nxt;
  logic                 outdeg_fail_r, outdeg_fail_nxt;
  logic [1:0]           indeg_r   [MAX_NODES];
  logic [1:0]           indeg_nxt [MAX_NODES];
  logic [ROW_W-1:0]     adj_mem   [MAX_NODES];
  logic [ROW_W-1:0]     adj_rd_r;
  logic                 rd_ok_r;
  logic                 row_take;
  logic [MAX_NODES-1:0] row_ext;

  // rows past node_count are dropped
  assign row_take = row_wr && (row_cnt_r < n_eff);

  // row bits lined up with the node range
  generate
    if (MAX_NODES >= ROW_W) begin : g_ext_wide
      assign row_ext = MAX_NODES'(row_data);
    end else begin : g_ext_narrow
      assign row_ext = row_data[MAX_NODES-1:0];
    end
  endgenerate

  // counters and out-degree flag
  always_comb begin
    row_cnt_nxt     = row_cnt_r;
    outdeg_fail_nxt = outdeg_fail_r;
    for (int i = 0; i < MAX_NODES; i++) begin
      indeg_nxt[i] = indeg_r[i];
    end
    if (clear) begin
      row_cnt_nxt     = '0;
      outdeg_fail_nxt = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        indeg_nxt[i] = '0;
      end
    end else if (row_take) begin
      row_cnt_nxt = row_cnt_r + CW'(1);
      if ($countones(row_data) > 2) outdeg_fail_nxt = 1'b1;
      // saturating in-degree per column
      for (int i = 0; i < MAX_NODES; i++) begin
        if (row_ext[i] && (indeg_r[i] != 2'd3)) indeg_nxt[i] = indeg_r[i] + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r     <= '0;
      outdeg_fail_r <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        indeg_r[i] <= '0;
      end
    end else begin
      row_cnt_r     <= row_cnt_nxt;
      outdeg_fail_r <= outdeg_fail_nxt;
      for (int i = 0; i < MAX_NODES; i++) begin
        indeg_r[i] <= indeg_nxt[i];
      end
    end
  end

  // row memory, registered read; rows not loaded this graph read as empty
  always_ff @(posedge clk) begin
    if (row_take) adj_mem[row_cnt_r[NW-1:0]] <= row_data;
    adj_rd_r <= adj_mem[rd_node];
    rd_ok_r  <= (CW'(rd_node) < row_cnt_r);
  end

  assign rsp.outdeg_failed = outdeg_fail_r;
  assign rsp.indegree      = indeg_r[scan_idx];
  assign rsp.row           = rd_ok_r ? adj_rd_r : '0;

endmodule

>>> hdl/dgbt_walk.sv
// verdict sequencer: in-degree scan, depth-first walk over a stack memory,
// visited map and output register; depends on dgbt_pkg
module dgbt_walk import dgbt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_clear,
  input  logic                                 in_valid,
  input  logic                                 in_last_row,
  output logic                                 in_stall,
  input  logic [$clog2(MAX_NODES+1)-1:0]       n_eff,
  input  logic [MAX_NODES-1:0]                 node_mask,
  input  store_rsp_t                           rsp,
  output logic                                 store_clear,
  output logic [$clog2(MAX_NODES)-1:0]         rd_node,
  output logic [$clog2(MAX_NODES)-1:0]         scan_idx,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_is_tree,
  output logic [REASON_W-1:0]                  out_fail_reason
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  walk_state_t          state_r, state_nxt;
  logic [NW-1:0]        idx_r, idx_nxt;
  logic [NW-1:0]        src_r, src_nxt;
  logic [1:0]           src_cnt_r, src_cnt_nxt;
  logic [CW-1:0]        sp_r, sp_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [ROW_W-1:0]     work_r, work_nxt;
  reason_t              reason_r, reason_nxt;
  reason_t              out_reason_r, out_reason_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [NW-1:0]        stack_mem [MAX_NODES];
  logic [NW-1:0]        stack_q_r;

  logic                 scan_last;
  logic                 scan_fail;
  logic [NW-1:0]        src_pick;
  logic [1:0]           cnt_pick;
  logic                 one_source;
  logic [ROW_LW-1:0]    child;
  logic                 stack_room;
  logic                 emit_go;
  logic                 push_src;
  logic                 push_child;
  logic                 stack_we;
  logic [NW-1:0]        stack_wa;
  logic [NW-1:0]        stack_wd;

  // scan step and expand step helpers
  always_comb begin
    scan_last  = (CW'(idx_r) == (n_eff - CW'(1)));
    scan_fail  = (rsp.indegree > 2'd1);
    src_pick   = (rsp.indegree == 2'd0) ? idx_r : src_r;
    cnt_pick   = src_cnt_r;
    if (rsp.indegree == 2'd0 && src_cnt_r != 2'd2) cnt_pick = src_cnt_r + 2'd1;
    one_source = (cnt_pick == 2'd1);
    child      = lowest_bit(work_r);
    stack_room = (sp_r < CW'(MAX_NODES));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last_row) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (n_eff == CW'(0) || n_eff == CW'(1) || rsp.outdeg_failed) state_nxt = ST_EMIT;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_fail) state_nxt = ST_EMIT;
        else if (scan_last) state_nxt = one_source ? ST_POP : ST_EMIT;
      end
      ST_POP: begin
        state_nxt = (sp_r == '0) ? ST_FINAL : ST_FETCH;
      end
      ST_FETCH:  state_nxt = ST_ROW;
      ST_ROW:    state_nxt = ST_EXPAND;
      ST_EXPAND: begin
        if (work_r == '0) state_nxt = ST_POP;
      end
      ST_FINAL:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_LOAD;
      end
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // control strobes
  always_comb begin
    in_stall    = (state_r != ST_LOAD);
    emit_go     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
    store_clear = emit_go || cfg_clear;
    push_src    = (state_r == ST_SCAN) && !scan_fail && scan_last && one_source;
    push_child  = (state_r == ST_EXPAND) && (work_r != '0) && stack_room;
  end

  // datapath next values
  always_comb begin
    idx_nxt        = idx_r;
    src_nxt        = src_r;
    src_cnt_nxt    = src_cnt_r;
    sp_nxt         = sp_r;
    visited_nxt    = visited_r;
    work_nxt       = work_r;
    reason_nxt     = reason_r;
    out_reason_nxt = out_reason_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      ST_CHECK: begin
        idx_nxt     = '0;
        src_cnt_nxt = '0;
        reason_nxt  = RSN_NONE;
        if (n_eff == CW'(0)) reason_nxt = RSN_SOURCE;
        else if (n_eff == CW'(1)) reason_nxt = RSN_NONE;
        else if (rsp.outdeg_failed) reason_nxt = RSN_OUTDEG;
      end
      ST_SCAN: begin
        idx_nxt     = NW'(idx_r + 1'b1);
        src_nxt     = src_pick;
        src_cnt_nxt = cnt_pick;
        if (scan_fail) reason_nxt = RSN_INDEG;
        else if (scan_last && !one_source) reason_nxt = RSN_SOURCE;
        else if (scan_last) begin
          visited_nxt = MAX_NODES'(1) << src_pick;
          sp_nxt      = CW'(1);
        end
      end
      ST_POP: begin
        if (sp_r != '0) sp_nxt = sp_r - CW'(1);
      end
      ST_ROW: work_nxt = rsp.row;
      ST_EXPAND: begin
        // one child per cycle: mark, push while the stack has room, clear its bit
        if (work_r != '0) begin
          work_nxt    = work_r & (work_r - ROW_W'(1));
          visited_nxt = visited_r | (MAX_NODES'(1) << child);
          if (stack_room) sp_nxt = sp_r + CW'(1);
        end
      end
      ST_FINAL: begin
        if ((visited_r & node_mask) == node_mask) reason_nxt = RSN_NONE;
        else reason_nxt = RSN_UNREACH;
      end
      default: ;
    endcase
    if (emit_go) begin
      out_reason_nxt = reason_r;
      out_valid_nxt  = 1'b1;
    end
    if (store_clear) begin
      visited_nxt = '0;
      sp_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      sp_r        <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    src_r        <= src_nxt;
    src_cnt_r    <= src_cnt_nxt;
    work_r       <= work_nxt;
    reason_r     <= reason_nxt;
    out_reason_r <= out_reason_nxt;
  end

  // walk stack: one push port, registered top-of-stack read
  always_comb begin
    stack_we = push_src || push_child;
    stack_wa = push_src ? '0 : NW'(sp_r);
    stack_wd = push_src ? src_pick : NW'(child);
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_q_r <= stack_mem[NW'(sp_r - CW'(1))];
  end

  assign rd_node         = stack_q_r;
  assign scan_idx        = idx_r;
  assign out_valid       = out_valid_r;
  assign out_is_tree     = (out_reason_r == RSN_NONE);
  assign out_fail_reason = out_reason_r;

  // stack depth never passes the node limit
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(MAX_NODES))
    else $error("walk stack pointer beyond node limit");

  // a verdict handed over shows up on the output with the computed reason
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && out_reason_r == $past(reason_r) && state_r == ST_LOAD))
    else $error("verdict not presented after emit");

  // the walk starts with only the source marked
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (push_src && !cfg_clear) |=> ($onehot(visited_r) && sp_r == CW'(1)))
    else $error("walk did not start from a single source");

  // an empty stack ends the walk
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP && sp_r == '0) |=> (state_r == ST_FINAL))
    else $error("walk continued on an empty stack");

endmodule

>>> hdl/digraph_binary_tree_check.sv
// top level of the digraph binary tree checker
// depends on dgbt_pkg, dgbt_store and dgbt_walk
//
// Usage: write node_count on cfg_wr_en/cfg_node_count while idle; a write
// drops any graph in progress. Then send the adjacency matrix one row per
// request on in_valid/in_stall, in row order, with in_last_row on the final
// row. Rows beyond node_count are ignored; rows never sent count as empty.
// Rows are taken one per cycle while in_stall is low. After the last row
// one verdict request (out_is_tree, out_fail_reason) comes out on
// out_valid/out_stall, after a check step, an in-degree scan, a depth-first
// walk that pops, fetches and reads each reached node's row and expands
// its children, a final step and the output register load; early failures
// finish sooner. The shared walk step and the single-port stack memory set
// the walk's pace. in_stall is high from the last row until the verdict
// enters the output register. The output register holds the verdict while
// out_stall is high; rows of the next graph are taken meanwhile.
// Synchronous reset sets node_count to 1 and clears the row count, degree
// state, walk stack and visited map; no clearing pass is needed.
module digraph_binary_tree_check import dgbt_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ROW_W-1:0]    in_row_bits,
  input  logic                in_last_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_tree,
  output logic [REASON_W-1:0] out_fail_reason,
  input  logic                cfg_wr_en,
  input  logic [CNT_W-1:0]    cfg_node_count
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [CNT_W-1:0]     node_count_r, node_count_nxt;
  logic [CW-1:0]        n_eff;
  logic [ROW_W-1:0]     col_mask;
  logic [MAX_NODES-1:0] node_mask;
  logic                 row_wr;
  logic                 store_clear;
  logic [NW-1:0]        rd_node;
  logic [NW-1:0]        scan_idx;
  store_rsp_t           rsp;

  // node count register
  assign node_count_nxt = cfg_wr_en ? cfg_node_count : node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(1);
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  // effective node count and column masks
  always_comb begin
    if (int'(node_count_r) > MAX_NODES) n_eff = CW'(MAX_NODES);
    else n_eff = CW'(node_count_r);
    for (int j = 0; j < ROW_W; j++) begin
      col_mask[j] = (j < int'(n_eff));
    end
    for (int j = 0; j < MAX_NODES; j++) begin
      node_mask[j] = (j < int'(n_eff));
    end
  end

  assign row_wr = in_valid && !in_stall;

  dgbt_store #(.MAX_NODES(MAX_NODES)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (store_clear),
    .row_wr   (row_wr),
    .row_data (in_row_bits & col_mask),
    .n_eff    (n_eff),
    .rd_node  (rd_node),
    .scan_idx (scan_idx),
    .rsp      (rsp)
  );

  dgbt_walk #(.MAX_NODES(MAX_NODES)) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_clear       (cfg_wr_en),
    .in_valid        (in_valid),
    .in_last_row     (in_last_row),
    .in_stall        (in_stall),
    .n_eff           (n_eff),
    .node_mask       (node_mask),
    .rsp             (rsp),
    .store_clear     (store_clear),
    .rd_node         (rd_node),
    .scan_idx        (scan_idx),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_tree     (out_is_tree),
    .out_fail_reason (out_fail_reason)
  );

endmodule

>>> sim/digraph_binary_tree_check_tb.sv
`timescale 1ns / 1ps
// testbench for digraph_binary_tree_check: streams adjacency rows, predicts each verdict
// depends on dgbt_pkg and digraph_binary_tree_check; holds its own scoreboard class

import dgbt_pkg::*;

// verdict predictor and store of expected verdicts
class tree_scoreboard;
  typedef struct {
    bit      tree;
    reason_t why;
  } verdict_t;

  logic [31:0] adj [32];
  logic [1:0]  indeg [32];
  int          rows_seen;
  bit          deg_fail;
  logic [5:0]  nodes;
  verdict_t    expected_q [$];
  int          errors;

  function new();
    nodes = 6'd1;
    errors = 0;
    clear_graph();
  endfunction

  function void clear_graph();
    rows_seen = 0;
    deg_fail = 1'b0;
    for (int i = 0; i < 32; i++) indeg[i] = 2'd0;
  endfunction

  function int eff_nodes();
    return (nodes > 6'd32) ? 32 : int'(nodes);
  endfunction

  function logic [31:0] col_mask(int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
  endfunction

  // a node_count write drops the graph in progress
  function void write_count(logic [5:0] v);
    nodes = v;
    clear_graph();
  endfunction

  function verdict_t judge_graph();
    verdict_t    v;
    int          n;
    int          sources;
    int          root;
    logic [31:0] seen;
    logic [31:0] full;
    n = eff_nodes();
    v.tree = 1'b0;
    v.why = RSN_NONE;
    if (n == 0) begin
      v.why = RSN_SOURCE;
      return v;
    end
    if (n == 1) begin
      v.tree = 1'b1;
      return v;
    end
    if (deg_fail) begin
      v.why = RSN_OUTDEG;
      return v;
    end
    for (int i = 0; i < n; i++) begin
      if (indeg[i] > 2'd1) begin
        v.why = RSN_INDEG;
        return v;
      end
    end
    sources = 0;
    root = 0;
    for (int i = 0; i < n; i++) begin
      if (indeg[i] == 2'd0) begin
        root = i;
        sources++;
      end
    end
    if (sources != 1) begin
      v.why = RSN_SOURCE;
      return v;
    end
    // reachability from the source; rows never received have no edges
    seen = 32'h1 << root;
    repeat (n) begin
      for (int i = 0; i < n; i++) begin
        if (seen[i] && i < rows_seen) seen = seen | adj[i];
      end
    end
    full = col_mask(n);
    if ((seen & full) != full) begin
      v.why = RSN_UNREACH;
      return v;
    end
    v.tree = 1'b1;
    return v;
  endfunction

  // accepted row request
  function void note_request(logic [31:0] row_in, bit last);
    int          n;
    int          deg;
    logic [31:0] row;
    n = eff_nodes();
    row = row_in & col_mask(n);
    deg = 0;
    if (rows_seen < n) begin
      adj[rows_seen] = row;
      for (int j = 0; j < n; j++) begin
        if (row[j]) begin
          deg++;
          if (indeg[j] != 2'd3) indeg[j]++;
        end
      end
      if (deg > 2) deg_fail = 1'b1;
      rows_seen++;
    end
    if (last) begin
      expected_q.push_back(judge_graph());
      clear_graph();
    end
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // accepted verdict request
  function void check_result(bit tree, logic [2:0] why);
    verdict_t exp_v;
    if (expected_q.size() == 0) begin
      flag($sformatf("unexpected verdict: tree=%0d reason=%0d", tree, why));
      return;
    end
    exp_v = expected_q.pop_front();
    if (tree !== exp_v.tree || why !== exp_v.why)
      flag($sformatf("verdict mismatch: expected tree=%0d reason=%0d, got tree=%0d reason=%0d",
                     exp_v.tree, exp_v.why, tree, why));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module digraph_binary_tree_check_tb;
  localparam int SETTLE_CYCLES = 200;
  localparam int ROW_TARGET    = 1100;
  localparam int QUIET_TAIL    = 150;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ROW_W-1:0]    in_row_bits;
  logic                in_last_row;
  logic                out_valid;
  logic                out_stall;
  logic                out_is_tree;
  logic [REASON_W-1:0] out_fail_reason;
  logic                cfg_wr_en;
  logic [CNT_W-1:0]    cfg_node_count;

  tree_scoreboard sb;
  bit             idle_on;
  int             rows_sent;
  int             verdicts_seen;
  int             stall_left;

  digraph_binary_tree_check DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_bits    (in_row_bits),
    .in_last_row    (in_last_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_tree    (out_is_tree),
    .out_fail_reason(out_fail_reason),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_node_count (cfg_node_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // verdict check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_is_tree, out_fail_reason);
      verdicts_seen++;
    end
  end

  // one row request; entered and left at a falling edge
  task automatic send_row(input logic [31:0] row, input bit last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row_bits <= row;
    in_last_row <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(row, last);
    rows_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every verdict is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_nodes(input logic [5:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_node_count <= v;
    sb.write_count(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random binary tree, optionally damaged, then sent with a random row count
  task automatic send_graph(input int n_cfg);
    logic [31:0] rows [40];
    int          perm [32];
    int          parent [32];
    int          outdeg [32];
    int          n;
    int          count;
    int          start;
    int          p;
    int          j;
    int          tmp;
    int          v;
    logic [31:0] cols;
    n = (n_cfg > 32) ? 32 : n_cfg;
    cols = sb.col_mask(n);
    for (int i = 0; i < 40; i++) rows[i] = (i < n) ? 32'h0 : $urandom;
    for (int i = 0; i < 32; i++) begin
      perm[i] = i;
      parent[i] = 0;
      outdeg[i] = 0;
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    // attach each node to an earlier one with a free child slot
    for (int k = 1; k < n; k++) begin
      start = $urandom_range(0, k - 1);
      p = perm[start];
      for (int t = 0; t < k; t++) begin
        p = perm[(start + t) % k];
        if (outdeg[p] < 2) break;
      end
      rows[p][perm[k]] = 1'b1;
      outdeg[p]++;
      parent[perm[k]] = p;
    end
    if (n >= 2) begin
      case ($urandom_range(0, 9))
        // extra edge
        5: rows[$urandom_range(0, n - 1)][$urandom_range(0, n - 1)] = 1'b1;
        // detach a subtree and close it with a self loop
        6: begin
          v = perm[$urandom_range(1, n - 1)];
          rows[parent[v]][v] = 1'b0;
          rows[v][v] = 1'b1;
        end
        // missing edge, second source
        7: begin
          v = perm[$urandom_range(1, n - 1)];
          rows[parent[v]][v] = 1'b0;
        end
        // sparse noise
        8: for (int i = 0; i < n; i++) rows[i] = $urandom & $urandom;
        // junk above the used columns
        9: for (int i = 0; i < n; i++) rows[i] = rows[i] | ($urandom & ~cols);
        default: ;
      endcase
    end
    count = n;
    if (n == 0) begin
      count = $urandom_range(1, 3);
    end else begin
      case ($urandom_range(0, 11))
        0: count = $urandom_range(1, n);
        1: count = n + $urandom_range(1, 3);
        default: ;
      endcase
    end
    for (int i = 0; i < count; i++) send_row(rows[i], i == count - 1);
    if (idle_on && $urandom_range(0, 19) == 0) drain();
  endtask

  initial begin
    int          n_cfg;
    int          graphs;
    int          pick;
    sb = new();
    idle_on = 1'b1;
    rows_sent = 0;
    verdicts_seen = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_row_bits = '0;
    in_last_row = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_node_count = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single node after reset, self loop ignored
    send_row(32'hFFFF_FFFF, 1'b1);
    // zero nodes, no source
    set_nodes(6'd0);
    send_row(32'hFFFF_FFFF, 1'b1);
    // three nodes: tree, out-degree, in-degree, unreachable cycle, early last row
    set_nodes(6'd3);
    send_row(32'b110, 1'b0);
    send_row(32'b000, 1'b0);
    send_row(32'b000, 1'b1);
    send_row(32'b111, 1'b0);
    send_row(32'b000, 1'b0);
    send_row(32'b000, 1'b1);
    send_row(32'b100, 1'b0);
    send_row(32'b100, 1'b0);
    send_row(32'b000, 1'b1);
    send_row(32'b000, 1'b0);
    send_row(32'b100, 1'b0);
    send_row(32'b010, 1'b1);
    send_row(32'b010, 1'b1);
    // extra rows are ignored, last flag on an extra row still ends the graph
    set_nodes(6'd2);
    send_row(32'b10, 1'b0);
    send_row(32'b00, 1'b0);
    send_row(32'b11, 1'b0);
    send_row(32'b11, 1'b1);
    // node count above the limit saturates
    set_nodes(6'd63);
    send_row(32'hFFFF_FFFF, 1'b1);
    // a write mid graph drops the rows taken so far
    set_nodes(6'd2);
    send_row(32'b10, 1'b0);
    set_nodes(6'd2);
    send_row(32'b00, 1'b0);
    send_row(32'b01, 1'b1);

    // random phases of node counts and graphs
    while (rows_sent < ROW_TARGET || verdicts_seen < 60) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) n_cfg = 0;
      else if (pick == 1) n_cfg = $urandom_range(33, 63);
      else if (pick == 2) n_cfg = 32;
      else if (pick <= 4) n_cfg = $urandom_range(9, 31);
      else n_cfg = $urandom_range(1, 8);
      set_nodes(6'(n_cfg));
      graphs = (n_cfg > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
      repeat (graphs) begin
        if (rows_sent >= ROW_TARGET - QUIET_TAIL) idle_on = 1'b0;
        send_graph(n_cfg);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/dgbt_pkg.sv
hdl/dgbt_store.sv
hdl/dgbt_walk.sv
hdl/digraph_binary_tree_check.sv
sim/digraph_binary_tree_check_tb.sv
